@@ sv/rps_pkg.sv @@
// Package for the random permutation shuffle core.
// Holds the beat structs and the fixed widths and constants that the core and the
// modulo unit share. No dependencies.
`timescale 1ns / 1ps

package rps_pkg;

    // Generator and field widths
    localparam int GEN_W   = 32;
    localparam int COUNT_W = 7;
    localparam int POS_W   = 6;
    localparam int LABEL_W = 6;

    // xorshift32 shift amounts
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    // Modulo unit: dividend bits retired per cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = GEN_W / DIV_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [GEN_W-1:0]   seed;
        logic [COUNT_W-1:0] item_count;
    } rps_request_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [LABEL_W-1:0] label;
        logic               last;
        logic [GEN_W-1:0]   seed_after;
    } rps_result_t;

endpackage

@@ sv/rps_modulo.sv @@
// Iterative modulo unit: 32-bit dividend mod a narrow divisor.
// Restoring shift-subtract, DIV_BITS dividend bits per cycle. Depends on rps_pkg.
`timescale 1ns / 1ps

module rps_modulo #(
    parameter int DW = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [rps_pkg::GEN_W-1:0] dividend,
    input  logic [DW-1:0]          divisor,
    output logic                   done,
    output logic [DW-1:0]          remainder
);
    import rps_pkg::*;

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [GEN_W-1:0]      dvd_reg, dvd_next;
    logic [DW-1:0]         dsr_reg, dsr_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         rem_step;

    // DIV_BITS restoring steps on a remainder of DW bits
    always_comb
    begin
        logic [DW:0]   trial;
        logic [DW-1:0] r;
        r = rem_reg;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            trial = {r, dvd_reg[GEN_W-1-b]};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
            end
            r = trial[DW-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        dvd_next    = dvd_reg;
        dsr_next    = dsr_reg;
        rem_next    = rem_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            dvd_next    = dividend;
            dsr_next    = divisor;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            rem_next  = rem_step;
            dvd_next  = dvd_reg << DIV_BITS;
            step_next = step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/random_permutation_shuffle_core.sv @@
// Top level of the random permutation shuffle core: sequencer, order and label stores.
// Depends on rps_pkg and rps_modulo.
`timescale 1ns / 1ps

// Usage
// - Request beat: drive request (seed, item_count) and raise start; the beat is taken
//   at a rising edge with start high and busy low. busy stays high until the last
//   result has been registered.
// - Result beats: n of them, for positions 0..n-1 in order, each on result for one
//   cycle with valid high. The last carries last = 1 and the advanced seed; seed_after
//   reads zero on the others. The receiver cannot stall; no back-pressure exists.
// - Counts above MAX_ITEMS saturate to MAX_ITEMS. A count of zero gives no results
//   and busy never rises.
// - Sequence for a count n >= 2, start to last result: fill the order store, run n - 1
//   swaps, invert the order into the label store, then emit the results.
//   Each swap is dominated by the modulo unit: four 8-bit restoring steps and a done
//   step, then a read and two writes through the single write port of the order
//   store. A count of one skips the swaps.
// - Reset clears the sequencer, the generator and the result strobe; the stores are
//   not cleared, as every request fills what it reads.
module random_permutation_shuffle_core #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rps_pkg::rps_request_t request,
    output logic                  busy,
    output logic                  valid,
    output rps_pkg::rps_result_t  result
);
    import rps_pkg::*;

    localparam int IW = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1; // store index
    localparam int CW = $clog2(MAX_ITEMS + 1);                   // count / divisor
    localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;           // saturation compare

    // Sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_GEN    = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_WR_I   = 4'd5;
    localparam logic [3:0] S_WR_J   = 4'd6;
    localparam logic [3:0] S_INV_RD = 4'd7;
    localparam logic [3:0] S_INV_WR = 4'd8;
    localparam logic [3:0] S_OUT_RD = 4'd9;
    localparam logic [3:0] S_OUT_WR = 4'd10;

    function automatic logic [GEN_W-1:0] xorshift32(input logic [GEN_W-1:0] s);
        logic [GEN_W-1:0] x;
        x = s ^ (s << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

    logic [3:0]       state_reg, state_next;
    logic [GEN_W-1:0] gen_reg, gen_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    j_reg, j_next;
    logic             valid_reg, valid_next;
    rps_result_t      result_reg, result_next;

    // Stores
    logic [IW-1:0] order_mem [MAX_ITEMS];
    logic [IW-1:0] label_mem [MAX_ITEMS];
    logic [IW-1:0] order_rd_a_reg, order_rd_b_reg, label_rd_reg;
    logic          order_we, label_we;
    logic [IW-1:0] order_waddr, order_wdata, order_ra, order_rb;
    logic [IW-1:0] label_waddr, label_wdata, label_ra;

    // Request count, saturated
    logic [SW-1:0] req_count;
    logic [CW-1:0] sat_count;
    logic [IW-1:0] last_idx;
    logic [GEN_W-1:0] gen_adv;

    // Modulo unit link
    logic          div_start, div_done;
    logic [CW-1:0] div_divisor, div_rem;

    assign req_count = SW'(request.item_count);
    assign sat_count = (req_count > SW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(req_count);
    assign last_idx  = IW'(count_reg - CW'(1));
    assign gen_adv   = xorshift32(gen_reg);

    assign div_start   = (state_reg == S_GEN);
    assign div_divisor = CW'(idx_reg) + CW'(1);

    rps_modulo #(
        .DW(CW)
    ) u_modulo (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (gen_adv),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        gen_next    = gen_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        valid_next  = 1'b0;
        result_next = result_reg;

        order_we    = 1'b0;
        order_waddr = idx_reg;
        order_wdata = idx_reg;
        order_ra    = idx_reg;
        order_rb    = j_reg;
        label_we    = 1'b0;
        label_waddr = order_rd_a_reg;
        label_wdata = idx_reg;
        label_ra    = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    gen_next   = request.seed;
                    count_next = sat_count;
                    idx_next   = '0;
                    if (sat_count != '0)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                // identity order, one entry a cycle
                order_we = 1'b1;
                if (idx_reg == last_idx)
                begin
                    state_next = (idx_reg == '0) ? S_INV_RD : S_GEN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_GEN:
            begin
                gen_next   = gen_adv;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    j_next     = IW'(div_rem);
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WR_I;
            end
            S_WR_I:
            begin
                order_we    = 1'b1;
                order_waddr = idx_reg;
                order_wdata = order_rd_b_reg;
                state_next  = S_WR_J;
            end
            S_WR_J:
            begin
                order_we    = 1'b1;
                order_waddr = j_reg;
                order_wdata = order_rd_a_reg;
                if (idx_reg == IW'(1))
                begin
                    idx_next   = '0;
                    state_next = S_INV_RD;
                end
                else
                begin
                    idx_next   = idx_reg - IW'(1);
                    state_next = S_GEN;
                end
            end
            S_INV_RD:
            begin
                state_next = S_INV_WR;
            end
            S_INV_WR:
            begin
                // label[order[k]] = k
                label_we = 1'b1;
                if (idx_reg == last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_INV_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_WR;
            end
            S_OUT_WR:
            begin
                valid_next           = 1'b1;
                result_next.position = POS_W'(idx_reg);
                result_next.label    = LABEL_W'(label_rd_reg);
                result_next.last     = (idx_reg == last_idx);
                result_next.seed_after = (idx_reg == last_idx) ? gen_reg : '0;
                if (idx_reg == last_idx)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gen_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            j_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            j_reg     <= j_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Order store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[order_waddr] <= order_wdata;
        end
        order_rd_a_reg <= order_mem[order_ra];
        order_rd_b_reg <= order_mem[order_rb];
    end

    // Label store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (label_we)
        begin
            label_mem[label_waddr] <= label_wdata;
        end
        label_rd_reg <= label_mem[label_ra];
    end

    assign busy   = (state_reg != S_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(state_reg) == S_OUT_WR)
        else $error("result beat outside the emit step");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.last |=> !valid)
        else $error("result beat straight after the last beat");

    a_seed_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !result.last |-> result.seed_after == '0)
        else $error("seed_after set on a non-final beat");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("modulo result while sequencer not waiting");

    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && sat_count != '0 |=> busy)
        else $error("non-empty request taken without raising busy");
`endif

endmodule
